// File: hw/rtl/idle_timeout_table_core_assert.svh
// Assertion macros for the idle timeout table checker.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef IDLE_TIMEOUT_TABLE_CORE_ASSERT_SVH
`define IDLE_TIMEOUT_TABLE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ITT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/itt_pkg.sv
// Package for the idle timeout table: field widths, operation codes and
// the request record that travels along the row of table cells.
package itt_pkg;

  localparam int unsigned KEY_W   = 10;
  localparam int unsigned TIME_W  = 31;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned SUM_W   = TIME_W + 1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd60;
  localparam logic [KEY_W-1:0]   KEY_EMPTY   = '0;

  typedef enum logic {
    FUNC_TOUCH = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  typedef struct packed {
    logic              vld;
    func_e             func;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
    logic              done;
    logic              found;
    logic [TIME_W-1:0] stamp;
  } pkt_t;

endpackage

// File: hw/rtl/itt_cell.sv
// One table cell: holds one key and its stamp and passes the request on.
// Depends on itt_pkg.
module itt_cell (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  itt_pkg::pkt_t pkt_i,
  output itt_pkg::pkt_t pkt_o
);
  import itt_pkg::*;

  logic [KEY_W-1:0]  key_q, key_d;
  logic [TIME_W-1:0] stamp_q, stamp_d;
  logic              vld_q;
  pkt_t              pay_q, pay_d;
  logic              live, hit, empty;

  always_comb begin
    live    = pkt_i.vld && !pkt_i.done;
    empty   = live && (key_q == KEY_EMPTY);
    hit     = live && (key_q != KEY_EMPTY) && (key_q == pkt_i.key);
    key_d   = key_q;
    stamp_d = stamp_q;
    if (pkt_i.func == FUNC_TOUCH && (hit || empty)) begin
      stamp_d = pkt_i.now;
      key_d   = pkt_i.key;
    end
    pay_d       = pkt_i;
    pay_d.done  = pkt_i.done || hit || empty;
    pay_d.found = pkt_i.found || hit;
    if (hit) begin
      pay_d.stamp = stamp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= KEY_EMPTY;
      vld_q <= 1'b0;
    end else begin
      key_q <= key_d;
      vld_q <= pkt_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    stamp_q <= stamp_d;
    pay_q   <= pay_d;
  end

  always_comb begin
    pkt_o     = pay_q;
    pkt_o.vld = vld_q;
  end

endmodule

// File: hw/rtl/idle_timeout_table_core.sv
// Idle timeout table. Each request walks a row of ENTRIES cells, one cell per
// cycle, and its result is then registered in the output register. Only one
// request is in flight: the next one is taken only after the previous result
// has been loaded into the output register. A result that finishes while the
// output register is stalled waits in a holding slot, and the input stays
// stalled until that result reaches the output register. Keys clear at reset
// with no pass. Depends on itt_pkg and itt_cell.
module idle_timeout_table_core #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [itt_pkg::LIMIT_W-1:0] cfg_idle_limit_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       in_func_i,
  input  logic [itt_pkg::KEY_W-1:0]  in_conn_key_i,
  input  logic [itt_pkg::TIME_W-1:0] in_now_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       out_found_o,
  output logic [itt_pkg::TIME_W-1:0] out_stamp_o,
  output logic                       out_idle_o,
  output logic                       out_dropped_o
);
  import itt_pkg::*;

  logic [LIMIT_W-1:0] idle_limit_q;
  logic               busy_q, busy_d;
  logic               pend_valid_q, pend_valid_d;
  pkt_t               pend_q;
  logic               out_valid_q, out_valid_d;
  logic               found_q, idle_q, dropped_q;
  logic [TIME_W-1:0]  stamp_q;
  logic               in_acc, out_free, load_out;
  pkt_t               chain_pkt [ENTRIES+1];
  pkt_t               src;
  logic [SUM_W-1:0]   limit_point;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy_q;
  assign in_acc      = in_valid_i && !busy_q;

  always_comb begin
    chain_pkt[0].vld   = in_acc;
    chain_pkt[0].func  = func_e'(in_func_i);
    chain_pkt[0].key   = in_conn_key_i;
    chain_pkt[0].now   = in_now_i;
    chain_pkt[0].done  = (in_conn_key_i == KEY_EMPTY);
    chain_pkt[0].found = 1'b0;
    chain_pkt[0].stamp = '0;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    itt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .pkt_i  (chain_pkt[i]),
      .pkt_o  (chain_pkt[i+1])
    );
  end

  always_comb begin
    out_free     = !out_valid_q || !out_stall_i;
    src          = pend_valid_q ? pend_q : chain_pkt[ENTRIES];
    load_out     = (pend_valid_q || chain_pkt[ENTRIES].vld) && out_free;
    pend_valid_d = pend_valid_q ? !load_out : (chain_pkt[ENTRIES].vld && !out_free);
    busy_d       = in_acc || (busy_q && !load_out);
    out_valid_d  = load_out || (out_valid_q && out_stall_i);
    limit_point  = {1'b0, src.stamp} + SUM_W'(idle_limit_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_limit_q <= LIMIT_RESET;
      busy_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        idle_limit_q <= cfg_idle_limit_i;
      end
      busy_q       <= busy_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!pend_valid_q && chain_pkt[ENTRIES].vld) begin
      pend_q <= chain_pkt[ENTRIES];
    end
    if (load_out) begin
      found_q   <= src.found;
      stamp_q   <= src.stamp;
      idle_q    <= src.found && (src.func == FUNC_QUERY) &&
                   (limit_point < {1'b0, src.now});
      dropped_q <= (src.func == FUNC_TOUCH) && !src.done;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_found_o   = found_q;
  assign out_stamp_o   = stamp_q;
  assign out_idle_o    = idle_q;
  assign out_dropped_o = dropped_q;

endmodule

// File: hw/rtl/itt_checker.sv
// Port-level checker for the idle timeout table, bound to the top level.
// Depends on itt_pkg and idle_timeout_table_core_assert.svh.
`include "idle_timeout_table_core_assert.svh"

module itt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       out_found_o,
  input logic [itt_pkg::TIME_W-1:0] out_stamp_o,
  input logic                       out_idle_o,
  input logic                       out_dropped_o
);

  `ITT_ASSERT_NEXT(a_busy_after_request, in_valid_i && !in_stall_o, in_stall_o,
    "A new request was taken while one was still in flight.")

  `ITT_ASSERT_SAME(a_idle_needs_found, out_valid_o && out_idle_o, out_found_o,
    "An idle result was reported for a key that was not found.")

  `ITT_ASSERT_SAME(a_absent_stamp_zero, out_valid_o && !out_found_o, out_stamp_o == '0,
    "A result for an absent key carried a nonzero stamp.")

  `ITT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_found_o) && $stable(out_stamp_o) &&
    $stable(out_idle_o) && $stable(out_dropped_o),
    "A stalled result changed.")

endmodule

bind idle_timeout_table_core itt_checker u_itt_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench for idle_timeout_table_core: touch and query requests
// are checked against a scoreboard that keeps its own copy of the key table.
// Depends on itt_pkg and the idle_timeout_table_core RTL.
`timescale 1ns / 1ps

module testbench;
  import itt_pkg::*;

  localparam int ENTRIES     = 64;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_ITEMS = 340;

  typedef struct packed {
    int unsigned       seq;
    logic              found;
    logic [TIME_W-1:0] stamp;
    logic              idle;
    logic              dropped;
  } result_t;

  class activity_scoreboard;
    logic [KEY_W-1:0]   key_tbl[ENTRIES];
    logic [TIME_W-1:0]  stamp_tbl[ENTRIES];
    logic [LIMIT_W-1:0] idle_limit;
    result_t            pending[$];
    int unsigned        seq_no;
    int                 errors;
    int                 touches;
    int                 queries;
    int                 hits;
    int                 idle_hits;
    int                 drops;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        key_tbl[i]   = KEY_EMPTY;
        stamp_tbl[i] = '0;
      end
      idle_limit = LIMIT_RESET;
      seq_no     = 0;
      errors     = 0;
      touches    = 0;
      queries    = 0;
      hits       = 0;
      idle_hits  = 0;
      drops      = 0;
    endfunction

    function void note_request(func_e op, logic [KEY_W-1:0] key, logic [TIME_W-1:0] now);
      result_t r;
      int      hit;
      int      free_at;
      r       = '0;
      hit     = -1;
      free_at = -1;
      r.seq   = seq_no;
      seq_no++;
      if (op == FUNC_TOUCH) touches++;
      else queries++;
      if (key != KEY_EMPTY) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (hit < 0 && free_at < 0) begin
            if (key_tbl[i] == KEY_EMPTY) free_at = i;
            else if (key_tbl[i] == key) hit = i;
          end
        end
        if (hit >= 0) begin
          r.found = 1'b1;
          r.stamp = stamp_tbl[hit];
          hits++;
        end
        if (op == FUNC_TOUCH) begin
          if (hit >= 0) begin
            stamp_tbl[hit] = now;
          end else if (free_at >= 0) begin
            key_tbl[free_at]   = key;
            stamp_tbl[free_at] = now;
          end else begin
            r.dropped = 1'b1;
            drops++;
          end
        end else if (hit >= 0) begin
          r.idle = (longint'(r.stamp) < longint'(now) - longint'(idle_limit));
          if (r.idle) idle_hits++;
        end
      end
      pending.push_back(r);
    endfunction

    task report_mismatch(input string what);
      $display("MISMATCH: %s", what);
      errors++;
    endtask

    task check_result(input result_t got);
      result_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result found=%0b stamp=%0d idle=%0b dropped=%0b",
                                  got.found, got.stamp, got.idle, got.dropped));
      end else begin
        want = pending.pop_front();
        if (got.found !== want.found)
          report_mismatch($sformatf("request %0d found %0b, expected %0b",
                                    want.seq, got.found, want.found));
        if (got.stamp !== want.stamp)
          report_mismatch($sformatf("request %0d stamp %0d, expected %0d",
                                    want.seq, got.stamp, want.stamp));
        if (got.idle !== want.idle)
          report_mismatch($sformatf("request %0d idle %0b, expected %0b",
                                    want.seq, got.idle, want.idle));
        if (got.dropped !== want.dropped)
          report_mismatch($sformatf("request %0d dropped %0b, expected %0b",
                                    want.seq, got.dropped, want.dropped));
      end
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [LIMIT_W-1:0] cfg_idle_limit_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               in_func_i;
  logic [KEY_W-1:0]   in_conn_key_i;
  logic [TIME_W-1:0]  in_now_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               out_found_o;
  logic [TIME_W-1:0]  out_stamp_o;
  logic               out_idle_o;
  logic               out_dropped_o;

  activity_scoreboard sb;
  result_t            seen;
  int                 cycle_count;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 limit_writes;
  logic [TIME_W-1:0]  wall;

  idle_timeout_table_core #(
    .ENTRIES(ENTRIES)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_idle_limit_i(cfg_idle_limit_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_func_i       (in_func_i),
    .in_conn_key_i   (in_conn_key_i),
    .in_now_i        (in_now_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_found_o     (out_found_o),
    .out_stamp_o     (out_stamp_o),
    .out_idle_o      (out_idle_o),
    .out_dropped_o   (out_dropped_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped by the cycle limit at %0d cycles.", cycle_count);
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.seq     = 0;
      seen.found   = out_found_o;
      seen.stamp   = out_stamp_o;
      seen.idle    = out_idle_o;
      seen.dropped = out_dropped_o;
      sb.check_result(seen);
    end
  end

  task automatic send_request(input func_e op, input logic [KEY_W-1:0] key,
                              input logic [TIME_W-1:0] now);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    in_func_i     <= op;
    in_conn_key_i <= key;
    in_now_i      <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(op, key, now);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i      <= 1'b1;
    cfg_idle_limit_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.idle_limit = value;
    limit_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(input int count);
    func_e             op;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
    int                pick;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 39) == 0) drain_results();
      op   = func_e'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 85) key = KEY_W'($urandom_range(1, 80));
      else if (pick < 95) key = KEY_W'($urandom_range(0, 1023));
      else key = KEY_EMPTY;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        wall = wall + TIME_W'($urandom_range(0, 40));
        now  = wall;
      end else if (pick < 80) begin
        wall = wall + TIME_W'($urandom_range(0, 150000));
        now  = wall;
      end else if (pick < 90) begin
        now = wall - TIME_W'($urandom_range(0, 100));
      end else if (pick < 95) begin
        now = TIME_W'($urandom);
      end else begin
        now = $urandom_range(0, 1) ? '1 : '0;
      end
      send_request(op, key, now);
    end
  endtask

  initial begin
    sb               = new();
    cycle_count      = 0;
    limit_writes     = 0;
    send_idle_pct    = 28;
    recv_idle_pct    = 71;
    wall             = TIME_W'($urandom_range(0, 1000));
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_idle_limit_i = '0;
    in_valid_i       = 1'b0;
    in_func_i        = FUNC_TOUCH;
    in_conn_key_i    = '0;
    in_now_i         = '0;
    out_stall_i      = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The table starts empty and the limit holds its reset value.
    send_request(FUNC_QUERY, 10'd5, 31'd100);
    send_request(FUNC_TOUCH, KEY_EMPTY, 31'd100);
    send_request(FUNC_QUERY, KEY_EMPTY, 31'd100);
    send_request(FUNC_TOUCH, 10'd1023, '1);
    send_request(FUNC_QUERY, 10'd1023, '1);
    send_request(FUNC_TOUCH, 10'd1, 31'd0);
    send_request(FUNC_QUERY, 10'd1, 31'd60);
    send_request(FUNC_QUERY, 10'd1, 31'd61);
    send_request(FUNC_QUERY, 10'd1, 31'd0);
    send_request(FUNC_TOUCH, 10'd1, 31'd200);
    send_request(FUNC_TOUCH, KEY_EMPTY, '1);
    send_request(FUNC_QUERY, 10'd1023, 31'd0);
    send_request(FUNC_TOUCH, 10'h2AA, 31'h2AAAAAAA);
    send_request(FUNC_TOUCH, 10'h155, 31'h55555555);
    send_request(FUNC_QUERY, 10'h2AA, 31'h55555555);
    send_request(FUNC_QUERY, 10'h155, 31'h2AAAAAAA);
    send_request(FUNC_TOUCH, 10'h155, 31'h55555556);
    send_request(FUNC_QUERY, KEY_EMPTY, '1);

    write_limit('0);
    run_random(RANDOM_ITEMS);

    write_limit('1);
    send_idle_pct = 71;
    recv_idle_pct = 28;
    run_random(RANDOM_ITEMS);

    write_limit(LIMIT_W'($urandom_range(1, 3000)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(RANDOM_ITEMS);

    drain_results();
    repeat (ENTRIES + 4) @(posedge clk_i);

    $display("Covered %0d requests (%0d touches, %0d queries) over %0d limit settings.",
             sb.seq_no, sb.touches, sb.queries, limit_writes + 1);
    $display("Seen %0d hits, %0d idle answers and %0d dropped touches; %0d mismatches.",
             sb.hits, sb.idle_hits, sb.drops, sb.errors);
    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/itt_pkg.sv
hw/rtl/itt_cell.sv
hw/rtl/idle_timeout_table_core.sv
hw/rtl/itt_checker.sv
tb/testbench.sv
